// ===== hdl/rpm_pkg.sv =====
// Shared constants and types of the radix page map engine.
`timescale 1ns / 1ps
package rpm_pkg;

  localparam int unsigned RPM_LEVEL_BITS  = 4;
  localparam int unsigned RPM_MAX_LEVELS  = 4;
  localparam int unsigned RPM_TABLE_COUNT = 64;
  localparam int unsigned RPM_VALUE_BITS  = 32;

  localparam int unsigned LEVELS_W = 3;
  localparam logic [LEVELS_W-1:0] LEVELS_RESET = 3'd4;
  localparam logic [0:0] REG_LEVELS = 1'b0;

  typedef enum logic [1:0] {
    CMD_GET = 2'd0,
    CMD_SET = 2'd1,
    CMD_DEL = 2'd2,
    CMD_CLR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_ZERO_VAL = 2'd2,
    ST_NO_TABLE = 2'd3
  } status_e;

endpackage

// ===== hdl/rpm_if.sv =====
// Item channels of the radix page map engine.
`timescale 1ns / 1ps
interface rpm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [15:0] key;
  logic [31:0] value;
  modport source (output valid, command, key, value, input ready);
  modport sink (input valid, command, key, value, output ready);
endinterface

interface rpm_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;
  logic        found;
  logic [1:0]  status;
  modport source (output valid, read_value, found, status, input ready);
  modport sink (input valid, read_value, found, status, output ready);
endinterface

// ===== hdl/rpm_ram.sv =====
// Generic one-write one-read RAM with registered read data.
`timescale 1ns / 1ps
module rpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

// ===== hdl/radix_page_map_engine.sv =====
// Top level of the radix page map engine: command sequencer over table memories.
`timescale 1ns / 1ps
// One item at a time. Errors, clear and lookups on an empty map answer in the
// cycle after acceptance. A get walks each level through S_WRD (read of the
// entry and presence memories) and S_WDT (use of the read data); a set walks,
// takes each new table through S_APOP and S_AGET and writes the leaf in S_LEAF;
// a delete walks, clears the leaf bit in S_DEL and, each time it frees a table,
// climbs a level through S_DRD, S_DLD and S_DEL. The walk is set by the
// registered read of the entry and presence memories.
module radix_page_map_engine
  import rpm_pkg::*;
#(
  parameter int unsigned LEVEL_BITS  = RPM_LEVEL_BITS,
  parameter int unsigned MAX_LEVELS  = RPM_MAX_LEVELS,
  parameter int unsigned TABLE_COUNT = RPM_TABLE_COUNT,
  parameter int unsigned VALUE_BITS  = RPM_VALUE_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  rpm_in_if.sink      in_i,
  rpm_out_if.source   out_o
);
  localparam int unsigned E   = 1 << LEVEL_BITS;
  localparam int unsigned TW  = $clog2(TABLE_COUNT);
  localparam int unsigned CW  = $clog2(TABLE_COUNT + 1);
  localparam int unsigned LVW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned LNW = $clog2(MAX_LEVELS + 1);
  localparam int unsigned EW  = (VALUE_BITS > TW) ? VALUE_BITS : TW;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_WRD  = 10'b0000000010,
    S_WDT  = 10'b0000000100,
    S_APOP = 10'b0000001000,
    S_AGET = 10'b0000010000,
    S_LEAF = 10'b0000100000,
    S_DEL  = 10'b0001000000,
    S_DRD  = 10'b0010000000,
    S_DLD  = 10'b0100000000,
    S_SPARE = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [LEVELS_W-1:0] levels_q, levels_d;
  logic root_v_q, root_v_d, root_pend_q, root_pend_d;
  logic [TW-1:0] root_q, root_d, cur_q, cur_d;
  logic [CW-1:0] stk_cnt_q, stk_cnt_d, fresh_q, fresh_d;
  cmd_e cmd_q, cmd_d;
  logic [15:0] key_q, key_d;
  logic [VALUE_BITS-1:0] val_q, val_d;
  logic [LVW-1:0] lvl_q, lvl_d;
  logic [TW-1:0] tabs_q [MAX_LEVELS];
  logic [TW-1:0] tabs_d [MAX_LEVELS];
  logic [E-1:0] row_q, row_d;
  logic out_v_q, out_v_d, found_q, found_d;
  logic [31:0] rv_q, rv_d;
  status_e status_q, status_d;

  logic ent_we, ent_re, row_we, row_re, stk_we, stk_re;
  logic [TW+LEVEL_BITS-1:0] ent_addr;
  logic [EW-1:0] ent_wdata, ent_rd;
  logic [TW-1:0] row_waddr, row_raddr, stk_waddr, stk_raddr, stk_wdata, stk_rd, new_t;
  logic [E-1:0] row_wdata, row_rd, onebit, new_row;
  logic [LNW-1:0] eff;
  logic [LVW-1:0] last;
  logic [LEVEL_BITS-1:0] idx;
  logic [CW-1:0] free_tot;
  logic oor, cfg_wr, in_fire, is_leaf, present;

  assign pready = 1'b1;
  assign prdata = 32'(levels_q);
  assign cfg_wr = psel & penable & pwrite;
  assign in_i.ready = (state_q == S_IDLE) && (!out_v_q || out_o.ready);
  assign in_fire = in_i.valid & in_i.ready;
  assign out_o.valid = out_v_q;
  assign out_o.read_value = rv_q;
  assign out_o.found = found_q;
  assign out_o.status = status_q;

  always_comb begin
    if (levels_q == '0) begin
      eff = LNW'(1);
    end else if (int'(levels_q) > int'(MAX_LEVELS)) begin
      eff = LNW'(MAX_LEVELS);
    end else begin
      eff = LNW'(levels_q);
    end
  end

  assign last = LVW'(int'(eff) - 1);
  assign idx = LEVEL_BITS'(key_q >> ((int'(eff) - 1 - int'(lvl_q)) * LEVEL_BITS));
  assign onebit = E'(1) << idx;
  assign is_leaf = (lvl_q == last);
  assign present = row_rd[idx];
  assign free_tot = CW'(stk_cnt_q + fresh_q);
  assign new_t = (stk_cnt_q != '0) ? stk_rd : TW'(fresh_q - CW'(1));
  assign new_row = row_q & ~onebit;

  always_comb begin
    oor = 1'b0;
    for (int b = 0; b < 16; b++) begin
      if (b >= int'(eff) * LEVEL_BITS && in_i.key[b]) begin
        oor = 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    levels_d = levels_q;
    root_v_d = root_v_q;
    root_pend_d = root_pend_q;
    root_d = root_q;
    cur_d = cur_q;
    stk_cnt_d = stk_cnt_q;
    fresh_d = fresh_q;
    cmd_d = cmd_q;
    key_d = key_q;
    val_d = val_q;
    lvl_d = lvl_q;
    tabs_d = tabs_q;
    row_d = row_q;
    out_v_d = out_v_q && !out_o.ready;
    rv_d = rv_q;
    found_d = found_q;
    status_d = status_q;
    ent_we = 1'b0;
    ent_re = 1'b0;
    ent_addr = {cur_q, idx};
    ent_wdata = EW'(val_q);
    row_we = 1'b0;
    row_re = 1'b0;
    row_waddr = cur_q;
    row_raddr = cur_q;
    row_wdata = row_q | onebit;
    stk_we = 1'b0;
    stk_re = 1'b0;
    stk_waddr = TW'(stk_cnt_q);
    stk_raddr = TW'(stk_cnt_q - CW'(1));
    stk_wdata = tabs_q[lvl_q];

    if (cfg_wr) begin
      levels_d = pwdata[LEVELS_W-1:0];
      root_v_d = 1'b0;
      stk_cnt_d = '0;
      fresh_d = CW'(TABLE_COUNT);
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_d = cmd_e'(in_i.command);
          key_d = in_i.key;
          val_d = VALUE_BITS'(in_i.value);
          lvl_d = '0;
          out_v_d = 1'b1;
          rv_d = '0;
          found_d = 1'b0;
          status_d = ST_OK;
          if (cmd_e'(in_i.command) == CMD_CLR) begin
            root_v_d = 1'b0;
            stk_cnt_d = '0;
            fresh_d = CW'(TABLE_COUNT);
          end else if (oor) begin
            status_d = ST_RANGE;
          end else if (cmd_e'(in_i.command) == CMD_SET &&
                       VALUE_BITS'(in_i.value) == '0) begin
            status_d = ST_ZERO_VAL;
          end else if (!root_v_q) begin
            if (cmd_e'(in_i.command) == CMD_SET) begin
              if (int'(eff) > int'(free_tot)) begin
                status_d = ST_NO_TABLE;
              end else begin
                out_v_d = 1'b0;
                root_pend_d = 1'b1;
                state_d = S_APOP;
              end
            end
          end else begin
            out_v_d = 1'b0;
            cur_d = root_q;
            state_d = S_WRD;
          end
        end
      end
      S_WRD: begin
        ent_re = 1'b1;
        row_re = 1'b1;
        tabs_d[lvl_q] = cur_q;
        state_d = S_WDT;
      end
      S_WDT: begin
        row_d = row_rd;
        state_d = S_IDLE;
        if (is_leaf) begin
          case (cmd_q)
            CMD_GET: begin
              out_v_d = 1'b1;
              rv_d = present ? 32'(ent_rd) : '0;
              found_d = present;
            end
            CMD_SET: state_d = S_LEAF;
            default: begin
              if (present) begin
                state_d = S_DEL;
              end else begin
                out_v_d = 1'b1;
              end
            end
          endcase
        end else if (present) begin
          cur_d = ent_rd[TW-1:0];
          lvl_d = lvl_q + LVW'(1);
          state_d = S_WRD;
        end else if (cmd_q == CMD_SET) begin
          if (int'(eff) - int'(lvl_q) - 1 > int'(free_tot)) begin
            out_v_d = 1'b1;
            status_d = ST_NO_TABLE;
          end else begin
            root_pend_d = 1'b0;
            state_d = S_APOP;
          end
        end else begin
          out_v_d = 1'b1;
        end
      end
      S_APOP: begin
        stk_re = (stk_cnt_q != '0);
        state_d = S_AGET;
      end
      S_AGET: begin
        if (stk_cnt_q != '0) begin
          stk_cnt_d = stk_cnt_q - CW'(1);
        end else begin
          fresh_d = fresh_q - CW'(1);
        end
        if (root_pend_q) begin
          root_pend_d = 1'b0;
          root_v_d = 1'b1;
          root_d = new_t;
          cur_d = new_t;
          tabs_d[0] = new_t;
          row_d = '0;
          state_d = is_leaf ? S_LEAF : S_APOP;
        end else begin
          ent_we = 1'b1;
          ent_wdata = EW'(new_t);
          row_we = 1'b1;
          cur_d = new_t;
          lvl_d = lvl_q + LVW'(1);
          tabs_d[lvl_q + LVW'(1)] = new_t;
          row_d = '0;
          state_d = (lvl_q + LVW'(1) == last) ? S_LEAF : S_APOP;
        end
      end
      S_LEAF: begin
        ent_we = 1'b1;
        row_we = 1'b1;
        out_v_d = 1'b1;
        state_d = S_IDLE;
      end
      S_DEL: begin
        row_we = 1'b1;
        row_waddr = tabs_q[lvl_q];
        row_wdata = new_row;
        if (new_row != '0) begin
          out_v_d = 1'b1;
          found_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          stk_we = 1'b1;
          stk_cnt_d = stk_cnt_q + CW'(1);
          if (lvl_q == '0) begin
            root_v_d = 1'b0;
            out_v_d = 1'b1;
            found_d = 1'b1;
            state_d = S_IDLE;
          end else begin
            lvl_d = lvl_q - LVW'(1);
            state_d = S_DRD;
          end
        end
      end
      S_DRD: begin
        row_re = 1'b1;
        row_raddr = tabs_q[lvl_q];
        state_d = S_DLD;
      end
      S_DLD: begin
        row_d = row_rd;
        state_d = S_DEL;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      levels_q <= LEVELS_RESET;
      root_v_q <= 1'b0;
      root_pend_q <= 1'b0;
      stk_cnt_q <= '0;
      fresh_q <= CW'(TABLE_COUNT);
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      levels_q <= levels_d;
      root_v_q <= root_v_d;
      root_pend_q <= root_pend_d;
      stk_cnt_q <= stk_cnt_d;
      fresh_q <= fresh_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q <= root_d;
    cur_q <= cur_d;
    cmd_q <= cmd_d;
    key_q <= key_d;
    val_q <= val_d;
    lvl_q <= lvl_d;
    tabs_q <= tabs_d;
    row_q <= row_d;
    rv_q <= rv_d;
    found_q <= found_d;
    status_q <= status_d;
  end

  rpm_ram #(.WIDTH(EW), .DEPTH(TABLE_COUNT * E)) u_entries (
    .clk_i, .we_i(ent_we), .waddr_i(ent_addr), .wdata_i(ent_wdata),
    .re_i(ent_re), .raddr_i(ent_addr), .rdata_o(ent_rd)
  );

  rpm_ram #(.WIDTH(E), .DEPTH(TABLE_COUNT)) u_present (
    .clk_i, .we_i(row_we), .waddr_i(row_waddr), .wdata_i(row_wdata),
    .re_i(row_re), .raddr_i(row_raddr), .rdata_o(row_rd)
  );

  rpm_ram #(.WIDTH(TW), .DEPTH(TABLE_COUNT)) u_free_stack (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .re_i(stk_re), .raddr_i(stk_raddr), .rdata_o(stk_rd)
  );

`ifndef SYNTH
  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q)) else $error("state not one-hot");
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(stk_cnt_q) + int'(fresh_q) <= int'(TABLE_COUNT)) else $error("free count overflow");
  a_pop_has_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_AGET |-> free_tot != '0) else $error("table taken from empty pool");
`endif
endmodule

// ===== bench/testbench.sv =====
// Self-checking testbench of the radix page map engine: directed table, random mix, predictor.
`timescale 1ns / 1ps
module testbench;
  import rpm_pkg::*;

  localparam int unsigned ENT   = 1 << RPM_LEVEL_BITS;
  localparam int unsigned SLOTS = RPM_TABLE_COUNT * ENT;

  typedef struct packed {
    logic [31:0] read_value;
    logic        found;
    status_e     status;
  } answer_t;

  typedef struct {
    bit          is_cfg;
    cmd_e        cmd;
    logic [15:0] key;
    logic [31:0] value;
    bit          typed;
    answer_t     ans;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  rpm_in_if  in_ch();
  rpm_out_if out_ch();

  radix_page_map_engine i_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_i(in_ch), .out_o(out_ch)
  );

  always #4 clk_i = ~clk_i;

  logic [2:0]  levels_reg;
  bit          root_valid;
  int unsigned root_tab;
  logic [31:0] entry_val [SLOTS];
  bit          entry_on [SLOTS];
  int unsigned occupancy [RPM_TABLE_COUNT];
  int unsigned free_stack [RPM_TABLE_COUNT];
  int unsigned free_cnt;

  answer_t pending_answers[$];
  int errors = 0;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic void free_tables();
    for (int i = 0; i < RPM_TABLE_COUNT; i++) begin
      free_stack[i] = i;
      occupancy[i] = 0;
    end
    free_cnt = RPM_TABLE_COUNT;
    root_valid = 1'b0;
    root_tab = 0;
  endfunction

  function automatic int unsigned eff_levels();
    if (levels_reg < 1) return 1;
    if (levels_reg > RPM_MAX_LEVELS) return RPM_MAX_LEVELS;
    return 32'(levels_reg);
  endfunction

  function automatic int unsigned slot_of(int unsigned t, logic [15:0] key,
                                          int unsigned eff, int unsigned l);
    return t * ENT + ((key >> ((eff - 1 - l) * RPM_LEVEL_BITS)) & (ENT - 1));
  endfunction

  function automatic int unsigned take_table();
    int unsigned t;
    free_cnt--;
    t = free_stack[free_cnt];
    for (int i = 0; i < ENT; i++) entry_on[t * ENT + i] = 1'b0;
    occupancy[t] = 0;
    return t;
  endfunction

  function automatic answer_t map_step(cmd_e cmd, logic [15:0] key, logic [31:0] val);
    answer_t a;
    int unsigned eff, d, s, t, l;
    int unsigned tabs [RPM_MAX_LEVELS];
    a = '{read_value: '0, found: 1'b0, status: ST_OK};
    eff = eff_levels();
    d = 0;
    if (cmd != CMD_CLR && root_valid) begin
      t = root_tab;
      for (l = 0; l < eff; l++) begin
        tabs[l] = t;
        d = l + 1;
        if (l + 1 == eff) break;
        s = slot_of(t, key, eff, l);
        if (!entry_on[s]) break;
        t = entry_val[s] % RPM_TABLE_COUNT;
      end
    end
    if (cmd == CMD_CLR) begin
      free_tables();
    end else if (eff * RPM_LEVEL_BITS < 16 && (key >> (eff * RPM_LEVEL_BITS)) != 0) begin
      a.status = ST_RANGE;
    end else if (cmd == CMD_GET) begin
      if (d == eff) begin
        s = slot_of(tabs[eff - 1], key, eff, eff - 1);
        if (entry_on[s]) begin
          a.read_value = entry_val[s];
          a.found = 1'b1;
        end
      end
    end else if (cmd == CMD_SET) begin
      if (val == 0) begin
        a.status = ST_ZERO_VAL;
      end else if (eff - d > free_cnt) begin
        a.status = ST_NO_TABLE;
      end else begin
        if (d == 0) begin
          root_tab = take_table();
          root_valid = 1'b1;
          tabs[0] = root_tab;
          d = 1;
        end
        for (l = d - 1; l + 1 < eff; l++) begin
          s = slot_of(tabs[l], key, eff, l);
          t = take_table();
          entry_val[s] = t;
          entry_on[s] = 1'b1;
          occupancy[tabs[l]]++;
          tabs[l + 1] = t;
        end
        s = slot_of(tabs[eff - 1], key, eff, eff - 1);
        if (!entry_on[s]) begin
          entry_on[s] = 1'b1;
          occupancy[tabs[eff - 1]]++;
        end
        entry_val[s] = val;
      end
    end else if (d == eff) begin
      s = slot_of(tabs[eff - 1], key, eff, eff - 1);
      if (entry_on[s]) begin
        a.found = 1'b1;
        l = eff - 1;
        forever begin
          s = slot_of(tabs[l], key, eff, l);
          entry_on[s] = 1'b0;
          if (occupancy[tabs[l]] > 0) occupancy[tabs[l]]--;
          if (occupancy[tabs[l]] > 0) break;
          if (free_cnt < RPM_TABLE_COUNT) begin
            free_stack[free_cnt] = tabs[l];
            free_cnt++;
          end
          if (l == 0) begin
            root_valid = 1'b0;
            break;
          end
          l--;
        end
      end
    end
    return a;
  endfunction

  task automatic send_item(cmd_e cmd, logic [15:0] key, logic [31:0] val,
                           bit typed, answer_t ans);
    answer_t a;
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.key <= key;
    in_ch.value <= val;
    do @(posedge clk_i); while (!in_ch.ready);
    a = map_step(cmd, key, val);
    pending_answers.push_back(typed ? ans : a);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_levels(logic [2:0] v);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {REG_LEVELS, 1'b0};
    pwdata <= {29'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    levels_reg = v;
    free_tables();
  endtask

  always @(posedge clk_i) begin
    answer_t w;
    if (out_ch.valid && out_ch.ready) begin
      if (pending_answers.size() == 0) begin
        report("unexpected item", out_ch.read_value, 32'd0);
      end else begin
        w = pending_answers.pop_front();
        if (out_ch.read_value !== w.read_value) report("read_value", out_ch.read_value, w.read_value);
        if (out_ch.found !== w.found) report("found", 32'(out_ch.found), 32'(w.found));
        if (out_ch.status !== w.status) report("status", 32'(out_ch.status), 32'(w.status));
      end
    end
  end

  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  initial begin
    #5ms;
    $display("radix_page_map_engine verification failed");
    $finish;
  end

  initial begin
    row_t rows[$];
    logic [15:0] key_pool [16];
    logic [2:0] phases [8] = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd0, 3'd7, 3'd5, 3'd4};
    logic [15:0] k;
    logic [31:0] v;
    int unsigned eff, r;
    cmd_e c;
    answer_t none;

    none = '{read_value: '0, found: 1'b0, status: ST_OK};
    in_ch.valid = 1'b0;
    in_ch.command = CMD_GET;
    in_ch.key = '0;
    in_ch.value = '0;
    levels_reg = LEVELS_RESET;
    free_tables();
    for (int i = 0; i < SLOTS; i++) begin
      entry_on[i] = 1'b0;
      entry_val[i] = '0;
    end

    rows.push_back('{0, CMD_GET, 16'h0000, 32'h0, 1, none});
    rows.push_back('{0, CMD_SET, 16'h0000, 32'h0, 1, '{'0, 1'b0, ST_ZERO_VAL}});
    rows.push_back('{0, CMD_SET, 16'hFFFF, 32'hFFFF_FFFF, 0, none});
    rows.push_back('{0, CMD_GET, 16'hFFFF, 32'h0, 1, '{32'hFFFF_FFFF, 1'b1, ST_OK}});
    rows.push_back('{0, CMD_SET, 16'h0000, 32'h1, 0, none});
    rows.push_back('{0, CMD_SET, 16'h0001, 32'h8000_0000, 0, none});
    rows.push_back('{0, CMD_GET, 16'h0000, 32'h0, 0, none});
    rows.push_back('{0, CMD_SET, 16'hFFFF, 32'h5, 0, none});
    rows.push_back('{0, CMD_GET, 16'hFFFF, 32'hDEAD_BEEF, 0, none});
    rows.push_back('{0, CMD_DEL, 16'h1234, 32'h0, 1, none});
    rows.push_back('{0, CMD_DEL, 16'hFFFF, 32'h0, 0, none});
    rows.push_back('{0, CMD_GET, 16'hFFFF, 32'h0, 1, none});
    rows.push_back('{0, CMD_DEL, 16'h0000, 32'h0, 0, none});
    rows.push_back('{0, CMD_GET, 16'h0001, 32'h0, 0, none});
    rows.push_back('{0, CMD_CLR, 16'hFFFF, 32'hFFFF_FFFF, 1, none});
    rows.push_back('{0, CMD_GET, 16'h0001, 32'h0, 1, none});
    rows.push_back('{1, CMD_GET, 16'h0, 32'h1, 0, none});
    rows.push_back('{0, CMD_SET, 16'h0010, 32'h7, 1, '{'0, 1'b0, ST_RANGE}});
    rows.push_back('{0, CMD_GET, 16'h8000, 32'h0, 1, '{'0, 1'b0, ST_RANGE}});
    rows.push_back('{0, CMD_DEL, 16'hFFF0, 32'h0, 1, '{'0, 1'b0, ST_RANGE}});
    rows.push_back('{0, CMD_SET, 16'h000F, 32'h9, 0, none});
    rows.push_back('{0, CMD_GET, 16'h000F, 32'h0, 1, '{32'h9, 1'b1, ST_OK}});
    rows.push_back('{0, CMD_DEL, 16'h000F, 32'h0, 1, '{'0, 1'b1, ST_OK}});

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_levels(rows[i].value[2:0]);
      else send_item(rows[i].cmd, rows[i].key, rows[i].value, rows[i].typed, rows[i].ans);
    end

    foreach (phases[p]) begin
      write_levels(phases[p]);
      eff = eff_levels();
      foreach (key_pool[i]) begin
        key_pool[i] = 16'($urandom() & ((1 << (eff * RPM_LEVEL_BITS)) - 1));
      end
      if (p == 7) quiet = 1'b1;
      for (int n = 0; n < 85; n++) begin
        if (p == 2 && n == 10) hold_req = 1'b1;
        if (p == 5 && n == 40) begin
          in_ch.valid <= 1'b0;
          @(posedge clk_i);
          while (pending_answers.size() != 0) @(posedge clk_i);
        end
        r = $urandom_range(0, 99);
        c = r < 36 ? CMD_GET : r < 72 ? CMD_SET : r < 98 ? CMD_DEL : CMD_CLR;
        k = $urandom_range(0, 1) ? key_pool[$urandom_range(0, 15)] : 16'($urandom());
        v = $urandom_range(0, 29) == 0 ? 32'h0 : $urandom();
        send_item(c, k, v, 0, none);
      end
    end

    drain();
    if (errors == 0) begin
      $display("radix_page_map_engine verification clean");
    end else begin
      $display("radix_page_map_engine verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rpm_pkg.sv
hdl/rpm_if.sv
hdl/rpm_ram.sv
hdl/radix_page_map_engine.sv
bench/testbench.sv
